[rtl/prn_pkg.sv]
`default_nettype none

package prn_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int DIM_W = 13;
	localparam int CNT_W = 12;
	localparam int IDX_W = 24;
	localparam int PROD_W = CNT_W + DIM_W;
	localparam int BYTE_W = 8;
	localparam int NORM_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = QPTR_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION_MODE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OPAQUE_ALPHA = 2'd3;

	localparam logic [1:0] ROT_NONE = 2'd0;
	localparam logic [1:0] ROT_CCW90 = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_CW90 = 2'd3;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_ALPHA_FAIL = 2'd1;
	localparam logic [1:0] STATUS_FRAME_FAILED = 2'd2;

	localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [1:0]       rotation;
		logic             opaque;
	} frame_cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0]  dx;
		logic [CNT_W-1:0]  dy;
		logic [DIM_W-1:0]  dw;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] alpha;
		logic [1:0]        status;
		logic              last;
	} pixel_item_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// The byte scaled by 32768/255 with rounding splits into 128*b plus
	// floor((128*b + 127) / 255); the second term uses a reciprocal estimate
	// that is at most one low, fixed by a single compare.
	function automatic logic [NORM_W-1:0] norm_byte(input logic [BYTE_W-1:0] b);
		logic [14:0] m;
		logic [23:0] est;
		logic [7:0]  q0;
		logic [16:0] q0x255;
		logic [16:0] rem;
		logic [7:0]  q;
		m = {b, 7'b0} + 15'd127;
		est = {1'b0, m, 8'b0} + 24'(m);
		q0 = est[23:16];
		q0x255 = {1'b0, q0, 8'b0} - 17'(q0);
		rem = 17'(m) - q0x255;
		q = (rem >= 17'd255) ? (q0 + 8'd1) : q0;
		return {1'b0, b, 7'b0} + NORM_W'(q);
	endfunction

endpackage

`default_nettype wire

[rtl/prn_front.sv]
`default_nettype none

module prn_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        restart,
	input  wire prn_pkg::frame_cfg_t         cfg,
	input  wire logic                        accept,
	input  wire logic [prn_pkg::BYTE_W-1:0]  red_byte,
	input  wire logic [prn_pkg::BYTE_W-1:0]  green_byte,
	input  wire logic [prn_pkg::BYTE_W-1:0]  blue_byte,
	input  wire logic [prn_pkg::BYTE_W-1:0]  alpha_byte,
	output prn_pkg::pixel_item_t             item
);

	logic [prn_pkg::CNT_W-1:0] column_q;
	logic [prn_pkg::CNT_W-1:0] row_q;
	logic                      failed_q;
	logic [prn_pkg::CNT_W-1:0] w_m1;
	logic [prn_pkg::CNT_W-1:0] h_m1;
	logic                      end_col;
	logic                      end_row;
	logic                      violation;

	assign w_m1 = prn_pkg::CNT_W'(cfg.width - prn_pkg::DIM_W'(1));
	assign h_m1 = prn_pkg::CNT_W'(cfg.height - prn_pkg::DIM_W'(1));
	assign end_col = (column_q == w_m1);
	assign end_row = (row_q == h_m1);
	assign violation = cfg.opaque && (alpha_byte != prn_pkg::ALPHA_OPAQUE);

	always_comb begin
		item.red = red_byte;
		item.green = green_byte;
		item.blue = blue_byte;
		item.alpha = alpha_byte;
		item.last = end_col && end_row;
		unique case (cfg.rotation)
			prn_pkg::ROT_CCW90: begin
				item.dx = row_q;
				item.dy = w_m1 - column_q;
				item.dw = cfg.height;
			end
			prn_pkg::ROT_180: begin
				item.dx = w_m1 - column_q;
				item.dy = h_m1 - row_q;
				item.dw = cfg.width;
			end
			prn_pkg::ROT_CW90: begin
				item.dx = h_m1 - row_q;
				item.dy = column_q;
				item.dw = cfg.height;
			end
			default: begin
				item.dx = column_q;
				item.dy = row_q;
				item.dw = cfg.width;
			end
		endcase
		priority if (failed_q) begin
			item.status = prn_pkg::STATUS_FRAME_FAILED;
		end else if (violation) begin
			item.status = prn_pkg::STATUS_ALPHA_FAIL;
		end else begin
			item.status = prn_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q <= '0;
			failed_q <= 1'b0;
		end else if (restart) begin
			column_q <= '0;
			row_q <= '0;
			failed_q <= 1'b0;
		end else if (accept) begin
			if (end_col && end_row) begin
				column_q <= '0;
				row_q <= '0;
				failed_q <= 1'b0;
			end else begin
				if (violation) begin
					failed_q <= 1'b1;
				end
				if (end_col) begin
					column_q <= '0;
					row_q <= row_q + prn_pkg::CNT_W'(1);
				end else begin
					column_q <= column_q + prn_pkg::CNT_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/prn_queue.sv]
`default_nettype none

module prn_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire prn_pkg::pixel_item_t  wr_item,
	output logic                       full,
	input  wire logic                  rd_en,
	output prn_pkg::pixel_item_t       rd_item,
	output logic                       empty
);

	prn_pkg::pixel_item_t              store_q [prn_pkg::QUEUE_DEPTH];
	logic [prn_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [prn_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [prn_pkg::QCNT_W-1:0]        count_q;
	logic                              do_wr;
	logic                              do_rd;

	assign full = (count_q == prn_pkg::QCNT_W'(prn_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_item = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + prn_pkg::QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + prn_pkg::QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + prn_pkg::QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - prn_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/prn_back.sv]
`default_nettype none

module prn_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire prn_pkg::pixel_item_t        in_item,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [prn_pkg::IDX_W-1:0]        dest_index,
	output logic [prn_pkg::NORM_W-1:0]       red_norm,
	output logic [prn_pkg::NORM_W-1:0]       green_norm,
	output logic [prn_pkg::NORM_W-1:0]       blue_norm,
	output logic [prn_pkg::NORM_W-1:0]       alpha_norm,
	output logic [1:0]                       status,
	output logic                             last_pixel
);

	logic                        valid_s1;
	logic [prn_pkg::PROD_W-1:0]  prod_s1;
	logic [prn_pkg::CNT_W-1:0]   dx_s1;
	logic [prn_pkg::NORM_W-1:0]  red_s1;
	logic [prn_pkg::NORM_W-1:0]  green_s1;
	logic [prn_pkg::NORM_W-1:0]  blue_s1;
	logic [prn_pkg::NORM_W-1:0]  alpha_s1;
	logic [1:0]                  status_s1;
	logic                        last_s1;
	logic                        valid_s2;
	logic                        ready_s1;
	logic                        ready_s2;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;
	assign out_valid = valid_s2;

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			prod_s1 <= prn_pkg::PROD_W'(in_item.dy) * prn_pkg::PROD_W'(in_item.dw);
			dx_s1 <= in_item.dx;
			red_s1 <= prn_pkg::norm_byte(in_item.red);
			green_s1 <= prn_pkg::norm_byte(in_item.green);
			blue_s1 <= prn_pkg::norm_byte(in_item.blue);
			alpha_s1 <= prn_pkg::norm_byte(in_item.alpha);
			status_s1 <= in_item.status;
			last_s1 <= in_item.last;
		end
		if (ready_s2 && valid_s1) begin
			dest_index <= prod_s1[prn_pkg::IDX_W-1:0] + prn_pkg::IDX_W'(dx_s1);
			red_norm <= red_s1;
			green_norm <= green_s1;
			blue_norm <= blue_s1;
			alpha_norm <= alpha_s1;
			status <= status_s1;
			last_pixel <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/pixel_rotate_normalize.sv]
// A pixel accepted by push passes the queue write, the product stage and the output
// stage before it is shown on the result ports; a low pop can stall it on the way.
// Throughput: one pixel per clock while pop is held high, with a single product stage.
// A four-word queue separates the counting front end from the arithmetic back end.
// Reset clears counters, queue and pipeline valid bits and loads width 1,
// height 1, no rotation and opaque alpha mode.
`default_nettype none

module pixel_rotate_normalize (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [prn_pkg::BYTE_W-1:0]     red_byte,
	input  wire logic [prn_pkg::BYTE_W-1:0]     green_byte,
	input  wire logic [prn_pkg::BYTE_W-1:0]     blue_byte,
	input  wire logic [prn_pkg::BYTE_W-1:0]     alpha_byte,
	output logic                                empty,
	input  wire logic                           pop,
	output logic [prn_pkg::IDX_W-1:0]           dest_index,
	output logic [prn_pkg::NORM_W-1:0]          red_norm,
	output logic [prn_pkg::NORM_W-1:0]          green_norm,
	output logic [prn_pkg::NORM_W-1:0]          blue_norm,
	output logic [prn_pkg::NORM_W-1:0]          alpha_norm,
	output logic [1:0]                          status,
	output logic                                last_pixel,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [prn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [prn_pkg::DIM_W-1:0]      cfg_data
);

	prn_pkg::frame_cfg_t   cfg_q;
	prn_pkg::pixel_item_t  front_item;
	prn_pkg::pixel_item_t  queue_item;
	logic                  cfg_wr;
	logic                  accept;
	logic                  queue_empty;
	logic                  back_ready;
	logic                  out_valid;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign accept = push && !full;
	assign empty = !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width <= prn_pkg::DIM_W'(1);
			cfg_q.height <= prn_pkg::DIM_W'(1);
			cfg_q.rotation <= prn_pkg::ROT_NONE;
			cfg_q.opaque <= 1'b1;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				prn_pkg::REG_SOURCE_WIDTH: begin
					cfg_q.width <= prn_pkg::clamp_dim(cfg_data,
						prn_pkg::DIM_W'(prn_pkg::MAX_WIDTH));
				end
				prn_pkg::REG_SOURCE_HEIGHT: begin
					cfg_q.height <= prn_pkg::clamp_dim(cfg_data,
						prn_pkg::DIM_W'(prn_pkg::MAX_HEIGHT));
				end
				prn_pkg::REG_ROTATION_MODE: begin
					cfg_q.rotation <= cfg_data[1:0];
				end
				prn_pkg::REG_OPAQUE_ALPHA: begin
					cfg_q.opaque <= cfg_data[0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	prn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_wr),
		.cfg        (cfg_q),
		.accept     (accept),
		.red_byte   (red_byte),
		.green_byte (green_byte),
		.blue_byte  (blue_byte),
		.alpha_byte (alpha_byte),
		.item       (front_item)
	);

	prn_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_item (front_item),
		.full    (full),
		.rd_en   (back_ready),
		.rd_item (queue_item),
		.empty   (queue_empty)
	);

	prn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (!queue_empty),
		.in_ready   (back_ready),
		.in_item    (queue_item),
		.out_valid  (out_valid),
		.out_ready  (pop),
		.dest_index (dest_index),
		.red_norm   (red_norm),
		.green_norm (green_norm),
		.blue_norm  (blue_norm),
		.alpha_norm (alpha_norm),
		.status     (status),
		.last_pixel (last_pixel)
	);

endmodule

`default_nettype wire

[rtl/prn_checker.sv]
`default_nettype none

module prn_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        empty,
	input  wire logic        pop,
	input  wire logic [23:0] dest_index,
	input  wire logic [15:0] red_norm,
	input  wire logic [15:0] alpha_norm,
	input  wire logic [1:0]  status,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status == prn_pkg::STATUS_OK || status == prn_pkg::STATUS_ALPHA_FAIL
			|| status == prn_pkg::STATUS_FRAME_FAILED))
		else $error("result word carries an undefined status");

	a_violation_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == prn_pkg::STATUS_ALPHA_FAIL) |-> (alpha_norm != 16'd32768))
		else $error("alpha violation reported on an opaque pixel");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (red_norm <= 16'd32768 && alpha_norm <= 16'd32768))
		else $error("normalized channel above one");

	a_held_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(dest_index) && $stable(status)))
		else $error("stalled result word changed");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind pixel_rotate_normalize prn_checker u_prn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.dest_index (dest_index),
	.red_norm   (red_norm),
	.alpha_norm (alpha_norm),
	.status     (status),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready)
);

`default_nettype wire
